### hdl/mlk_pkg.sv
// Shared types, constants and the letter code table of the Morse letter keyer.
package mlk_pkg;

    // Widths of the item fields and of the keying state
    localparam int unsigned NUM_LETTERS = 26;
    localparam int unsigned IDX_W       = 5;
    localparam int unsigned TICK_W      = 16;
    localparam int unsigned CODE_W      = 4;
    localparam int unsigned LEN_W       = 3;
    localparam int unsigned POS_W       = 3;

    // Configuration port
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOT_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS  = 2'd2;

    localparam logic [TICK_W-1:0] DOT_TICKS_RST  = 16'd300;
    localparam logic [TICK_W-1:0] DASH_TICKS_RST = 16'd900;
    localparam logic [TICK_W-1:0] GAP_TICKS_RST  = 16'd1000;

    // Command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Input action codes
    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_LETTER = 1'b1;

    // Classified request kinds
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_LETTER = 2'd1,
        CMD_DROP   = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [CODE_W-1:0]  code_bits;
        logic [LEN_W-1:0]   code_len;
    } t_cmd;

    // Handshake of the queue's read side
    typedef struct packed {
        logic valid;
        logic ready;
    } t_pop_hs;

    // Code table: {length, pattern}, pattern bit j is element j, 1 = dash
    function automatic logic [LEN_W+CODE_W-1:0] code_lookup(input logic [IDX_W-1:0] idx);
        logic [LEN_W+CODE_W-1:0] ent;
        unique case (idx)
            5'd0:    ent = {3'd2, 4'h2};  // A .-
            5'd1:    ent = {3'd4, 4'h1};  // B -...
            5'd2:    ent = {3'd4, 4'h5};  // C -.-.
            5'd3:    ent = {3'd3, 4'h1};  // D -..
            5'd4:    ent = {3'd1, 4'h0};  // E .
            5'd5:    ent = {3'd4, 4'h4};  // F ..-.
            5'd6:    ent = {3'd3, 4'h3};  // G --.
            5'd7:    ent = {3'd4, 4'h0};  // H ....
            5'd8:    ent = {3'd2, 4'h0};  // I ..
            5'd9:    ent = {3'd4, 4'hE};  // J .---
            5'd10:   ent = {3'd3, 4'h5};  // K -.-
            5'd11:   ent = {3'd4, 4'h2};  // L .-..
            5'd12:   ent = {3'd2, 4'h3};  // M --
            5'd13:   ent = {3'd2, 4'h1};  // N -.
            5'd14:   ent = {3'd3, 4'h7};  // O ---
            5'd15:   ent = {3'd4, 4'h6};  // P .--.
            5'd16:   ent = {3'd4, 4'hB};  // Q --.-
            5'd17:   ent = {3'd3, 4'h2};  // R .-.
            5'd18:   ent = {3'd3, 4'h0};  // S ...
            5'd19:   ent = {3'd1, 4'h1};  // T -
            5'd20:   ent = {3'd3, 4'h4};  // U ..-
            5'd21:   ent = {3'd4, 4'h8};  // V ...-
            5'd22:   ent = {3'd3, 4'h6};  // W .--
            5'd23:   ent = {3'd4, 4'h9};  // X -..-
            5'd24:   ent = {3'd4, 4'hD};  // Y -.--
            5'd25:   ent = {3'd4, 4'h3};  // Z --..
            default: ent = '0;
        endcase
        return ent;
    endfunction

endpackage

### hdl/mlk_in_if.sv
// Input channel of the Morse letter keyer: tick or letter requests.
interface mlk_in_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [mlk_pkg::IDX_W-1:0] letter_index;

    modport source (output valid, output action, output letter_index, input ready);
    modport sink   (input valid, input action, input letter_index, output ready);
endinterface

### hdl/mlk_out_if.sv
// Result channel of the Morse letter keyer: LED level and status flags.
interface mlk_out_if;
    logic valid;
    logic ready;
    logic led_on;
    logic busy_res;
    logic accepted;
    logic dropped;
    logic letter_done;

    modport source (output valid, output led_on, output busy_res, output accepted,
                    output dropped, output letter_done, input ready);
    modport sink   (input valid, input led_on, input busy_res, input accepted,
                    input dropped, input letter_done, output ready);
endinterface

### hdl/morse_letter_keyer_unit.sv
// Top level of the Morse letter keyer: front end, command queue and back end.
//
// Usage:
//   i_in carries requests: action 0 is one time tick, action 1 offers the
//   letter letter_index (0 = A .. 25 = Z). Every request gives exactly one
//   result on o_out: LED level, busy flag, accepted / dropped for letters and
//   letter_done on the tick that ends the last gap of a letter.
//   A letter is taken only while no letter is being keyed; otherwise, or when
//   the index is above 25, it is reported as dropped and keying goes on.
//   i_cfg_we / i_cfg_idx / i_cfg_data write dot, dash and gap lengths in
//   ticks (index 0, 1, 2); write them only while the block is idle.
// Timing:
//   A request passes through the two-entry command queue and then the back
//   end's result register before its result appears. One request per cycle
//   is sustained while o_out.ready stays high.
// Reset:
//   i_rst_n (synchronous, active low) empties the queue and the result
//   register, sets the block idle and loads 300 / 900 / 1000 ticks.
// Stall:
//   When o_out.ready is low the result is held; the queue absorbs up to two
//   more requests, then i_in.ready drops until results drain.
module morse_letter_keyer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mlk_in_if.sink                          i_in,
    mlk_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [mlk_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mlk_pkg::TICK_W-1:0]      i_cfg_data
);
    import mlk_pkg::*;

    logic    q_ready;
    logic    push;
    t_cmd    push_cmd;
    t_cmd    pop_cmd;
    t_pop_hs pop_hs;
    logic    pop_ready;

    mlk_front u_front (
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    mlk_queue u_queue (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (push),
        .i_cmd               (push_cmd),
        .o_ready             (q_ready),
        .o_pop_hs_valid_only (pop_hs),
        .i_pop_ready         (pop_ready),
        .o_cmd               (pop_cmd)
    );

    mlk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pop_hs    (pop_hs),
        .o_pop_ready (pop_ready),
        .i_cmd       (pop_cmd),
        .o_out       (o_out)
    );
endmodule

### hdl/mlk_front.sv
// Front end: accepts requests, classifies them and looks up the letter code.
module mlk_front (
    mlk_in_if.sink         i_in,
    input  logic           i_q_ready,
    output logic           o_push,
    output mlk_pkg::t_cmd  o_cmd
);
    import mlk_pkg::*;

    logic [LEN_W+CODE_W-1:0] code_ent;

    // Take a request whenever the queue has room
    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

    assign code_ent = code_lookup(i_in.letter_index);

    // Classify: tick, keyable letter, or letter out of range
    always_comb begin
        o_cmd.code_bits = code_ent[CODE_W-1:0];
        o_cmd.code_len  = code_ent[LEN_W+CODE_W-1:CODE_W];
        if (i_in.action == ACT_TICK) begin
            o_cmd.kind = CMD_TICK;
        end else if (i_in.letter_index < IDX_W'(NUM_LETTERS)) begin
            o_cmd.kind = CMD_LETTER;
        end else begin
            o_cmd.kind = CMD_DROP;
        end
    end
endmodule

### hdl/mlk_queue.sv
// Short command queue between the front end and the keying back end.
module mlk_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mlk_pkg::t_cmd   i_cmd,
    output logic            o_ready,
    output mlk_pkg::t_pop_hs o_pop_hs_valid_only,
    input  logic            i_pop_ready,
    output mlk_pkg::t_cmd   o_cmd
);
    import mlk_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0] r_count, n_count;
    logic                pop;

    assign o_ready = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign o_pop_hs_valid_only.valid = (r_count != '0);
    assign o_pop_hs_valid_only.ready = i_pop_ready;
    assign pop     = (r_count != '0) && i_pop_ready;
    assign o_cmd   = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed request
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end
endmodule

### hdl/mlk_back.sv
// Back end: configuration registers, keying state and the result register.
module mlk_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mlk_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mlk_pkg::TICK_W-1:0]      i_cfg_data,
    input  mlk_pkg::t_pop_hs                i_pop_hs,
    output logic                            o_pop_ready,
    input  mlk_pkg::t_cmd                   i_cmd,
    mlk_out_if.source                       o_out
);
    import mlk_pkg::*;

    logic [TICK_W-1:0] r_dot_ticks, r_dash_ticks, r_gap_ticks;

    logic [CODE_W-1:0] r_code_bits, n_code_bits;
    logic [LEN_W-1:0]  r_code_len,  n_code_len;
    logic [POS_W-1:0]  r_pos,       n_pos;
    logic              r_in_gap,    n_in_gap;
    logic [TICK_W-1:0] r_ticks,     n_ticks;
    logic              r_active,    n_active;

    logic              r_out_valid;
    logic              r_led_on, r_busy, r_accepted, r_dropped, r_done;
    logic              accepted, dropped, done;
    logic              pop;
    logic [POS_W-1:0]  pos_inc;

    // Load a result whenever the output register is empty or being taken
    assign o_pop_ready = !r_out_valid || o_out.ready;
    assign pop         = i_pop_hs.valid && o_pop_ready;
    assign pos_inc     = r_pos + 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_ticks  <= DOT_TICKS_RST;
            r_dash_ticks <= DASH_TICKS_RST;
            r_gap_ticks  <= GAP_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DOT_TICKS:  r_dot_ticks  <= i_cfg_data;
                CFG_DASH_TICKS: r_dash_ticks <= i_cfg_data;
                CFG_GAP_TICKS:  r_gap_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Step the keying state for one request
    always_comb begin
        n_code_bits = r_code_bits;
        n_code_len  = r_code_len;
        n_pos       = r_pos;
        n_in_gap    = r_in_gap;
        n_ticks     = r_ticks;
        n_active    = r_active;
        accepted    = 1'b0;
        dropped     = 1'b0;
        done        = 1'b0;
        if (pop) begin
            unique case (i_cmd.kind)
                CMD_LETTER: begin
                    if (!r_active) begin
                        n_code_bits = i_cmd.code_bits;
                        n_code_len  = i_cmd.code_len;
                        n_pos       = '0;
                        n_active    = 1'b1;
                        n_in_gap    = 1'b0;
                        n_ticks     = i_cmd.code_bits[0] ? r_dash_ticks : r_dot_ticks;
                        accepted    = 1'b1;
                    end else begin
                        dropped = 1'b1;
                    end
                end
                CMD_DROP: begin
                    dropped = 1'b1;
                end
                CMD_TICK: begin
                    if (r_active) begin
                        if (r_ticks > TICK_W'(1)) begin
                            n_ticks = r_ticks - 1'b1;
                        end else if (!r_in_gap) begin
                            n_in_gap = 1'b1;
                            n_ticks  = r_gap_ticks;
                        end else if (pos_inc >= r_code_len) begin
                            n_active = 1'b0;
                            n_in_gap = 1'b0;
                            n_ticks  = '0;
                            n_pos    = '0;
                            done     = 1'b1;
                        end else begin
                            n_pos    = pos_inc;
                            n_in_gap = 1'b0;
                            n_ticks  = r_code_bits[pos_inc[1:0]] ? r_dash_ticks
                                                                 : r_dot_ticks;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_bits <= '0;
            r_code_len  <= '0;
            r_pos       <= '0;
            r_in_gap    <= 1'b0;
            r_ticks     <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_code_bits <= n_code_bits;
            r_code_len  <= n_code_len;
            r_pos       <= n_pos;
            r_in_gap    <= n_in_gap;
            r_ticks     <= n_ticks;
            r_active    <= n_active;
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_led_on   <= n_active && !n_in_gap;
            r_busy     <= n_active;
            r_accepted <= accepted;
            r_dropped  <= dropped;
            r_done     <= done;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.led_on      = r_led_on;
    assign o_out.busy_res    = r_busy;
    assign o_out.accepted    = r_accepted;
    assign o_out.dropped     = r_dropped;
    assign o_out.letter_done = r_done;
endmodule

### hdl/mlk_checker.sv
// Port-level checks on the Morse letter keyer and their attachment to the top level.
module mlk_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_led_on,
    input logic i_busy_res,
    input logic i_accepted,
    input logic i_dropped,
    input logic i_letter_done
);
    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // A letter is either taken or refused, never both
    a_acc_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_accepted && i_dropped))
        else $error("letter both accepted and dropped");

    // A taken letter starts keying with the LED lit
    a_acc_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_accepted |-> i_busy_res && i_led_on)
        else $error("accepted letter not keying");

    // A finished letter leaves the block idle and dark
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_letter_done |-> !i_busy_res && !i_led_on && !i_accepted)
        else $error("letter done while still busy");
endmodule

bind morse_letter_keyer_unit mlk_checker u_mlk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_led_on      (o_out.led_on),
    .i_busy_res    (o_out.busy_res),
    .i_accepted    (o_out.accepted),
    .i_dropped     (o_out.dropped),
    .i_letter_done (o_out.letter_done)
);

### tb/testbench.sv
// Self-checking testbench for the Morse letter keyer: predicted LED and status per request.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mlk_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int     HOLD_OFF_CYCLES    = 200;
    localparam int     DRAIN_CYCLES       = 6;
    localparam int     RANDOM_PHASE_ITEMS = 60;
    localparam int     MAX_REPORTS        = 10;
    localparam longint TIMEOUT_NS         = 64'd8_000_000;

    localparam logic [IDX_W-1:0] LTR_A        = 5'd0;
    localparam logic [IDX_W-1:0] LTR_E        = 5'd4;
    localparam logic [IDX_W-1:0] LTR_N        = 5'd13;
    localparam logic [IDX_W-1:0] LTR_O        = 5'd14;
    localparam logic [IDX_W-1:0] LTR_T        = 5'd19;
    localparam logic [IDX_W-1:0] LTR_Z        = 5'd25;
    localparam logic [IDX_W-1:0] LTR_PAST_Z   = 5'd26;
    localparam logic [IDX_W-1:0] IDX_ALL_ONES = 5'd31;

    // Letter patterns: {element count, pattern}, pattern bit j is element j, 1 = dash
    localparam logic [6:0] MORSE_CODES [26] = '{
        7'h22, 7'h41, 7'h45, 7'h31, 7'h10, 7'h44, 7'h33, 7'h40, 7'h20,
        7'h4E, 7'h35, 7'h42, 7'h23, 7'h21, 7'h37, 7'h46, 7'h4B, 7'h32,
        7'h30, 7'h11, 7'h34, 7'h48, 7'h36, 7'h49, 7'h4D, 7'h43
    };

    typedef struct packed {
        logic led_on;
        logic busy;
        logic taken;
        logic refused;
        logic done;
    } t_keyer_result;

    // Keying predictor plus the queue of results still owed by the block
    class keyer_scoreboard;
        logic [TICK_W-1:0] dot_len, dash_len, gap_len, ticks_left;
        logic [CODE_W-1:0] pattern;
        logic [LEN_W-1:0]  length;
        logic [POS_W-1:0]  position;
        bit                in_gap, keying;
        t_keyer_result     pending[$];
        int                mismatches, requests, ticks, taken, refused, finished;

        function new();
            dot_len  = DOT_TICKS_RST;
            dash_len = DASH_TICKS_RST;
            gap_len  = GAP_TICKS_RST;
            ticks_left = '0;
            pattern  = '0;
            length   = '0;
            position = '0;
            in_gap   = 1'b0;
            keying   = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] data);
            case (idx)
                CFG_DOT_TICKS:  dot_len  = data;
                CFG_DASH_TICKS: dash_len = data;
                CFG_GAP_TICKS:  gap_len  = data;
                default: ;
            endcase
        endfunction

        // Load the lit phase of the element at the current position
        function void load_element();
            ticks_left = pattern[position[1:0]] ? dash_len : dot_len;
            in_gap     = 1'b0;
        endfunction

        // Advance the keying state by one accepted request and queue its result
        function void note_request(logic act, logic [IDX_W-1:0] idx);
            t_keyer_result res;
            res = '0;
            requests++;
            if (act == ACT_LETTER) begin
                if (!keying && idx < NUM_LETTERS) begin
                    {length, pattern} = MORSE_CODES[idx];
                    position  = '0;
                    keying    = 1'b1;
                    load_element();
                    res.taken = 1'b1;
                    taken++;
                end else begin
                    res.refused = 1'b1;
                    refused++;
                end
            end else begin
                ticks++;
                if (keying) begin
                    if (ticks_left > 1) begin
                        ticks_left = ticks_left - 1'b1;
                    end else if (!in_gap) begin
                        in_gap     = 1'b1;
                        ticks_left = gap_len;
                    end else begin
                        position = position + 1'b1;
                        if (position >= length) begin
                            keying     = 1'b0;
                            in_gap     = 1'b0;
                            ticks_left = '0;
                            position   = '0;
                            res.done   = 1'b1;
                            finished++;
                        end else begin
                            load_element();
                        end
                    end
                end
            end
            res.led_on = keying && !in_gap;
            res.busy   = keying;
            pending.push_back(res);
        endfunction

        // Compare one result with the oldest outstanding prediction
        function void check_result(t_keyer_result got);
            t_keyer_result exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result %b with no request outstanding", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"ERROR: result mismatch (exp/got) led %b/%b busy %b/%b ",
                              "accepted %b/%b dropped %b/%b letter_done %b/%b"},
                             exp.led_on, got.led_on, exp.busy, got.busy,
                             exp.taken, got.taken, exp.refused, got.refused,
                             exp.done, got.done);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [TICK_W-1:0]    i_cfg_data;

    mlk_in_if  in_if ();
    mlk_out_if out_if ();

    morse_letter_keyer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    keyer_scoreboard sb;
    bit              idle_en;
    bit              hold_off_req;
    int              held_cycles;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Count cycles where the block refuses an offered request
    initial held_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && !in_if.ready)
            held_cycles++;
    end

    function automatic int draw_gap();
        return idle_en ? int'($urandom_range(0, 10)) : 0;
    endfunction

    function automatic logic [IDX_W-1:0] IDX_WIDTH_RAND();
        return IDX_W'($urandom_range(0, 31));
    endfunction

    // Offer one request; entered and left at a falling edge
    task automatic send_request(input logic act, input logic [IDX_W-1:0] idx);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.action       <= act;
        in_if.letter_index <= idx;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_request(act, idx);
        @(negedge i_clk);
    endtask

    // Tick until the current letter has been keyed to its end
    task automatic settle_idle();
        while (sb.keying)
            send_request(ACT_TICK, IDX_WIDTH_RAND());
    endtask

    // Hold the sender until every outstanding result has arrived
    task automatic quiesce();
        in_if.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Write all timing registers and the unused index back to back
    task automatic set_timing(input logic [TICK_W-1:0] dot, input logic [TICK_W-1:0] dash,
                              input logic [TICK_W-1:0] gap, input logic [TICK_W-1:0] junk);
        write_reg(CFG_DOT_TICKS, dot);
        write_reg(CFG_DASH_TICKS, dash);
        write_reg(CFG_GAP_TICKS, gap);
        write_reg(CFG_UNUSED, junk);
        i_cfg_we <= 1'b0;
    endtask

    // Random ticks and letters, letters mostly while idle, with busy and bad letters mixed in
    task automatic run_random_phase(input int n_items, input bit with_hold, input bit with_pause);
        int r;
        for (int k = 0; k < n_items; k++) begin
            if (with_hold && k == n_items / 3)
                hold_off_req = 1'b1;
            if (with_pause && k == n_items / 2)
                quiesce();
            r = $urandom_range(0, 99);
            if (!sb.keying) begin
                if (r < 40)
                    send_request(ACT_LETTER, IDX_W'($urandom_range(0, NUM_LETTERS - 1)));
                else if (r < 46)
                    send_request(ACT_LETTER, IDX_W'($urandom_range(NUM_LETTERS, 31)));
                else
                    send_request(ACT_TICK, IDX_WIDTH_RAND());
            end else if (r < 8) begin
                send_request(ACT_LETTER, IDX_WIDTH_RAND());
            end else begin
                send_request(ACT_TICK, IDX_WIDTH_RAND());
            end
        end
        settle_idle();
    endtask

    // Drain results with random stalls and an occasional long hold-off
    initial begin : result_sink
        int stall;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            stall = draw_gap();
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            sb.check_result({out_if.led_on, out_if.busy_res, out_if.accepted,
                             out_if.dropped, out_if.letter_done});
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("ERROR: timeout with %0d results outstanding", sb.pending.size());
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int fails;
        sb = new();
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.action       = ACT_TICK;
        in_if.letter_index = '0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_DOT_TICKS;
        i_cfg_data         = '0;
        idle_en            = 1'b1;
        hold_off_req       = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset lengths: idle tick, one letter, refused letters while keying
        send_request(ACT_TICK, IDX_ALL_ONES);
        send_request(ACT_LETTER, LTR_E);
        send_request(ACT_LETTER, IDX_ALL_ONES);
        send_request(ACT_LETTER, LTR_Z);
        idle_en = 1'b0;
        settle_idle();
        quiesce();

        // Short lengths; the write to the unused index must change nothing
        idle_en = 1'b1;
        set_timing(16'd1, 16'd2, 16'd1, 16'hFFFF);
        send_request(ACT_LETTER, LTR_Z);
        send_request(ACT_LETTER, LTR_A);
        send_request(ACT_LETTER, LTR_PAST_Z);
        settle_idle();
        send_request(ACT_LETTER, LTR_PAST_Z);
        send_request(ACT_LETTER, LTR_O);
        send_request(ACT_LETTER, LTR_T);
        settle_idle();
        send_request(ACT_TICK, LTR_A);
        quiesce();

        // Zero lengths behave like one
        set_timing(16'd0, 16'd3, 16'd0, 16'h0000);
        send_request(ACT_LETTER, LTR_N);
        settle_idle();
        quiesce();

        // Longer dot, dash and gap, run back to back
        idle_en = 1'b0;
        set_timing(16'd40, 16'd70, 16'd25, TICK_W'($urandom));
        send_request(ACT_LETTER, LTR_A);
        settle_idle();
        quiesce();

        // Random traffic over several timing settings
        idle_en = 1'b1;
        set_timing(16'd1, 16'd1, 16'd1, TICK_W'($urandom));
        run_random_phase(RANDOM_PHASE_ITEMS, 1'b0, 1'b0);
        quiesce();
        set_timing(16'd0, 16'd0, 16'd0, TICK_W'($urandom));
        run_random_phase(RANDOM_PHASE_ITEMS, 1'b0, 1'b1);
        quiesce();
        idle_en = 1'b0;
        set_timing(TICK_W'($urandom_range(1, 4)), TICK_W'($urandom_range(1, 4)),
                   TICK_W'($urandom_range(1, 4)), TICK_W'($urandom));
        run_random_phase(RANDOM_PHASE_ITEMS, 1'b1, 1'b0);
        quiesce();
        idle_en = 1'b1;
        set_timing(TICK_W'($urandom_range(0, 6)), TICK_W'($urandom_range(0, 6)),
                   TICK_W'($urandom_range(0, 6)), TICK_W'($urandom));
        run_random_phase(RANDOM_PHASE_ITEMS, 1'b0, 1'b1);
        quiesce();
        set_timing(TICK_W'($urandom_range(2, 12)), TICK_W'($urandom_range(2, 12)),
                   TICK_W'($urandom_range(2, 12)), TICK_W'($urandom));
        run_random_phase(RANDOM_PHASE_ITEMS, 1'b1, 1'b0);
        quiesce();

        // Report and close
        fails = sb.mismatches + sb.pending.size();
        if (sb.pending.size() != 0)
            $display("ERROR: %0d expected results never arrived", sb.pending.size());
        $display("Run covered %0d requests (%0d ticks), %0d letters taken, %0d refused, %0d keyed",
                 sb.requests, sb.ticks, sb.taken, sb.refused, sb.finished);
        $display("Timing from zero to 1000 ticks; input held off for %0d cycles; %0d mismatches",
                 held_cycles, sb.mismatches);
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
